/* rtl/assert_macros.svh */
// Assertion helpers included by line_turn_sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/lts_pkg.sv */
package lts_pkg;

   localparam int unsigned SENSOR_COUNT = 8;
   localparam int unsigned BITS_W       = 8;
   localparam int unsigned SPEED_W      = 10;
   localparam int unsigned CMD_W        = 11;

   // 2^19 / 10 rounded up; exact quotient for dividends below 43690
   localparam logic [15:0] RECIP_TEN    = 16'd52429;

   localparam logic KIND_START  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_S3_OFF     = 4'd1,
      PH_S0_ON      = 4'd2,
      PH_S0_OFF     = 4'd3,
      PH_S3_ON      = 4'd4,
      PH_S3_OFF_B   = 4'd5,
      PH_S7_ON      = 4'd6,
      PH_S7_OFF     = 4'd7,
      PH_FIN_S3_OFF = 4'd8,
      PH_FIN_S0_ON  = 4'd9,
      PH_FIN_S3_ON  = 4'd10,
      PH_FIN_S4_ON  = 4'd11
   } phase_type;

   // Sensor lookup in turn order; sensors beyond the input bits read as off.
   function automatic logic sensor_on(input logic [BITS_W-1:0] bits,
                                      input logic              rev,
                                      input int unsigned       idx);
      int unsigned src;
      src = rev ? (SENSOR_COUNT - 1 - idx) : idx;
      if (idx >= SENSOR_COUNT || src >= BITS_W) begin
         return 1'b0;
      end
      return bits[src[2:0]];
   endfunction

   function automatic logic [CMD_W-1:0] apply_sign(input logic [SPEED_W-1:0] mag,
                                                   input logic               neg);
      logic [CMD_W-1:0] ext;
      ext = {1'b0, mag};
      return neg ? (~ext + CMD_W'(1)) : ext;
   endfunction

endpackage

/* rtl/line_turn_sequencer.sv */
// line_turn_sequencer: in-place turn sequencer driven by sensor sample requests.
// Path: input register, then result register; a request moves on from the input
//   register once the result register is free or its response is taken.
// Throughput: 1 request per cycle while rsp_ready is high; the input register, when
//   empty, takes a new request while a finished response waits in the result register.
// Reset (synchronous, active high): idle, speed 0, base speed 200, both registers empty.
module line_turn_sequencer
   import lts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_wr_en,
   input  logic [SPEED_W-1:0]       csr_wr_data,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic [7:0]               req_turn_count,
   input  logic                     req_turn_right,
   input  logic [BITS_W-1:0]        req_sensor_bits,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [CMD_W-1:0]  rsp_speed_cmd,
   output logic                     rsp_speed_changed,
   output logic                     rsp_busy_res,
   output logic                     rsp_finished
);

`include "assert_macros.svh"

   // ---------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------
   logic [SPEED_W-1:0] base_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_speed_ff <= SPEED_W'(200);
      end else if (csr_wr_en) begin
         base_speed_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------
   // Input register: holds one request until the result stage is free
   // ---------------------------------------------------------------
   logic              in_valid_ff;
   logic              in_kind_ff;
   logic [7:0]        in_count_ff;
   logic              in_right_ff;
   logic [BITS_W-1:0] in_bits_ff;
   logic              out_valid_ff;
   logic              advance;

   // Move the held request into the result register when that slot frees up.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_kind_ff  <= req_kind;
         in_count_ff <= req_turn_count;
         in_right_ff <= req_turn_right;
         in_bits_ff  <= req_sensor_bits;
      end
   end

   // ---------------------------------------------------------------
   // Turn state
   // ---------------------------------------------------------------
   phase_type         phase_ff, phase_in;
   logic [7:0]        crossings_ff, crossings_in;
   logic              reverse_ff, reverse_in;
   logic [CMD_W-1:0]  speed_ff, speed_in;
   logic              changed_in, done_in;

   // Speed scaling: 0.8x as (8m + 5) / 10 by reciprocal multiply, 0.5x as (m + 1) / 2.
   logic [12:0]        dividend;
   logic [28:0]        product;
   logic [SPEED_W-1:0] speed_80;
   logic [SPEED_W:0]   half_sum;
   logic [SPEED_W-1:0] speed_50;

   assign dividend = {base_speed_ff, 3'b000} + 13'd5;
   assign product  = 29'(dividend) * 29'(RECIP_TEN);
   assign speed_80 = product[28:19];
   assign half_sum = {1'b0, base_speed_ff} + {{SPEED_W{1'b0}}, 1'b1};
   assign speed_50 = half_sum[SPEED_W:1];

   // Condition of the wait step in progress, in turn order.
   logic s0, s3, s4, s7, wait_met;

   always_comb begin
      s0 = sensor_on(in_bits_ff, reverse_ff, 0);
      s3 = sensor_on(in_bits_ff, reverse_ff, 3);
      s4 = sensor_on(in_bits_ff, reverse_ff, 4);
      s7 = sensor_on(in_bits_ff, reverse_ff, 7);
      case (phase_ff)
         PH_S3_OFF:     wait_met = !s3;
         PH_S0_ON:      wait_met = s0;
         PH_S0_OFF:     wait_met = !s0;
         PH_S3_ON:      wait_met = s3;
         PH_S3_OFF_B:   wait_met = !s3;
         PH_S7_ON:      wait_met = s7;
         PH_S7_OFF:     wait_met = !s7;
         PH_FIN_S3_OFF: wait_met = !s3;
         PH_FIN_S0_ON:  wait_met = s0;
         PH_FIN_S3_ON:  wait_met = s3;
         PH_FIN_S4_ON:  wait_met = s4;
         default:       wait_met = 1'b0;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      crossings_in = crossings_ff;
      reverse_in   = reverse_ff;
      speed_in     = speed_ff;
      changed_in   = 1'b0;
      done_in      = 1'b0;
      if (in_kind_ff == KIND_START) begin
         // A start drops any running turn and arms a new one.
         reverse_in   = in_right_ff;
         crossings_in = (in_count_ff > 8'd1) ? (in_count_ff - 8'd1) : 8'd0;
         speed_in     = apply_sign(base_speed_ff, in_right_ff);
         changed_in   = 1'b1;
         phase_in     = (crossings_in != 8'd0) ? PH_S3_OFF : PH_FIN_S3_OFF;
      end else if (wait_met) begin
         case (phase_ff)
            PH_S7_OFF: begin
               // One line crossed; loop again or begin the final approach.
               crossings_in = crossings_ff - 8'd1;
               phase_in     = (crossings_in != 8'd0) ? PH_S3_OFF : PH_FIN_S3_OFF;
            end
            PH_FIN_S0_ON: begin
               speed_in   = apply_sign(speed_80, reverse_ff);
               changed_in = 1'b1;
               phase_in   = PH_FIN_S3_ON;
            end
            PH_FIN_S3_ON: begin
               speed_in   = apply_sign(speed_50, reverse_ff);
               changed_in = 1'b1;
               phase_in   = PH_FIN_S4_ON;
            end
            PH_FIN_S4_ON: begin
               speed_in   = '0;
               changed_in = 1'b1;
               done_in    = 1'b1;
               phase_in   = PH_IDLE;
            end
            default: begin
               phase_in = phase_type'(phase_ff + 4'd1);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         crossings_ff <= 8'd0;
         reverse_ff   <= 1'b0;
         speed_ff     <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         crossings_ff <= crossings_in;
         reverse_ff   <= reverse_in;
         speed_ff     <= speed_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic [CMD_W-1:0] out_speed_ff;
   logic             out_changed_ff;
   logic             out_busy_ff;
   logic             out_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_speed_ff   <= speed_in;
         out_changed_ff <= changed_in;
         out_busy_ff    <= (phase_in != PH_IDLE);
         out_done_ff    <= done_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_speed_cmd     = $signed(out_speed_ff);
   assign rsp_speed_changed = out_changed_ff;
   assign rsp_busy_res      = out_busy_ff;
   assign rsp_finished      = out_done_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `ASSERT_IMPLIES(a_finish_stops, clock, reset, out_valid_ff && out_done_ff,
      out_speed_ff == '0 && out_changed_ff && !out_busy_ff)
   `ASSERT_IMPLIES(a_final_no_crossings, clock, reset,
      phase_ff == PH_IDLE || phase_ff == PH_FIN_S3_OFF || phase_ff == PH_FIN_S0_ON ||
      phase_ff == PH_FIN_S3_ON || phase_ff == PH_FIN_S4_ON, crossings_ff == 8'd0)
   `ASSERT_IMPLIES(a_idle_zero_speed, clock, reset, phase_ff == PH_IDLE, speed_ff == '0)
   `ASSERT_NEXT(a_held_request, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_bits_ff) && $stable(in_kind_ff))

endmodule
